/* rtl/core/bpa_pkg.sv */
// Package with payload types, codes and sequencer states of the page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_RESERVE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_NOT_INIT = 4'd1,
    ST_BAD_ARGS = 4'd2,
    ST_ALIGN    = 4'd3,
    ST_RANGE    = 4'd4,
    ST_OOM      = 4'd5,
    ST_USED     = 4'd6,
    ST_DBL_FREE = 4'd7,
    ST_RESERVED = 4'd8
  } status_e;

  localparam logic [1:0] PG_FREE = 2'd0;
  localparam logic [1:0] PG_USED = 2'd1;
  localparam logic [1:0] PG_RSVD = 2'd2;
  localparam logic [1:0] PG_BAD  = 2'd3;

  localparam int unsigned CfgIdxBase = 0;
  localparam int unsigned CfgIdxPool = 1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] reserve_bytes;
    logic [12:0] pages_wanted;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] alloc_addr;
    logic [1:0]  page_state;
    logic [12:0] free_count;
    logic [12:0] used_count;
    logic [12:0] reserved_count;
    logic [12:0] peak_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_MARK,
    S_RSV,
    S_RD,
    S_RESP
  } state_e;

endpackage

/* rtl/core/bitmap_page_allocator_top.sv */
// Top level of the first-fit bitmap page allocator with its page state store.
`timescale 1ns / 1ps
// The allocator keeps a 2-bit state per page in a memory with one read port
// and one write port, and it handles one request at a time. in_ready_o is low
// from the request transfer until the result transfer. A request that fails
// its argument checks goes straight to the result. Query and free read their
// page and then decide on it. Alloc reads the store one page per cycle from
// page zero and then marks the run it found one page per cycle; a search that
// finds no run answers with ST_OOM. Reserve reads each page of its clipped
// range and then decides on it. Writing pool_pages starts a clearing pass over
// all MAX_PAGES pages during which no request is taken. The single store read
// port and the single scan counter make these steps run one after another.
module bitmap_page_allocator_top #(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [19:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpa_pkg::req_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpa_pkg::rsp_t       out_data_o
);
  import bpa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_PAGES);
  localparam int unsigned CW = IW + 1;
  localparam logic [31:0] PgMask = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

  // Page state store.
  logic [1:0] mem_q [MAX_PAGES];
  logic [1:0] rd_q;
  logic       we;
  logic [IW-1:0] waddr, raddr;
  logic [1:0] wdat;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdat;
    end
    rd_q <= mem_q[raddr];
  end

  state_e state_q, state_d;
  logic [19:0]   base_q;
  logic [CW-1:0] pool_q, pool_d;
  logic [12:0]   free_q, free_d, used_q, used_d, rsv_q, rsv_d, peak_q, peak_d;
  logic [CW-1:0] idx_q, idx_d, last_q, last_d, run_q, run_d, start_q, start_d;
  req_t          req_q;
  rsp_t          rsp_q, rsp_d;
  logic          fwd_q, fwd_d;

  // Address helpers.
  logic [31:0] base_a, span_a, limit_a, rs_start, rs_end, off;
  logic [CW-1:0] want;
  always_comb begin
    base_a   = 32'({base_q, {PAGE_SHIFT{1'b0}}});
    span_a   = 32'({pool_q, {PAGE_SHIFT{1'b0}}});
    limit_a  = base_a + span_a;
    rs_start = in_data_i.addr & ~PgMask;
    rs_end   = (in_data_i.addr + in_data_i.reserve_bytes + PgMask) & ~PgMask;
    if (rs_start < base_a) rs_start = base_a;
    if (rs_end > limit_a) rs_end = limit_a;
    off = in_data_i.addr - base_a;
    want = (in_data_i.pages_wanted > 13'(MAX_PAGES)) ? CW'(MAX_PAGES + 1)
                                                      : CW'(in_data_i.pages_wanted);
  end

  logic loc_ok;
  logic [3:0] loc_st;
  always_comb begin
    loc_ok = 1'b0;
    loc_st = ST_RANGE;
    if (pool_q == '0) loc_st = ST_NOT_INIT;
    else if ((in_data_i.addr & PgMask) != 32'd0) loc_st = ST_ALIGN;
    else if (in_data_i.addr < base_a) loc_st = ST_RANGE;
    else if (off >= span_a) loc_st = ST_RANGE;
    else if ({{(32-CW){1'b0}}, pool_q} <= 32'(off >> PAGE_SHIFT)) loc_st = ST_RANGE;
    else begin
      loc_ok = 1'b1;
      loc_st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      pool_q  <= '0;
      free_q  <= '0;
      used_q  <= '0;
      rsv_q   <= '0;
      peak_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pool_q  <= pool_d;
      free_q  <= free_d;
      used_q  <= used_d;
      rsv_q   <= rsv_d;
      peak_q  <= peak_d;
      idx_q   <= idx_d;
      if (cfg_we_i && cfg_idx_i == 1'(CfgIdxBase)) base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    run_q   <= run_d;
    start_q <= start_d;
    rsp_q   <= rsp_d;
    fwd_q   <= fwd_d;
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
  end

  // Sequencer: next state, store access and counter updates.
  always_comb begin
    logic [12:0] cv;
    cv = (cfg_data_i[12:0] > 13'(MAX_PAGES)) ? 13'(MAX_PAGES) : cfg_data_i[12:0];
    state_d = state_q;
    pool_d = pool_q; free_d = free_q; used_d = used_q; rsv_d = rsv_q; peak_d = peak_q;
    idx_d = idx_q; last_d = last_q; run_d = run_q; start_d = start_q;
    rsp_d = rsp_q; fwd_d = fwd_q;
    we = 1'b0; waddr = idx_q[IW-1:0]; wdat = PG_FREE; raddr = idx_q[IW-1:0];
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        rsp_d = '0;
        if (in_valid_i) begin
          idx_d = '0; run_d = '0; start_d = '0;
          state_d = S_RESP;
          case (func_e'(in_data_i.func))
            FUNC_ALLOC: begin
              if (pool_q == '0) rsp_d.status = ST_NOT_INIT;
              else if (in_data_i.pages_wanted == '0) rsp_d.status = ST_BAD_ARGS;
              else if (in_data_i.pages_wanted > free_q) rsp_d.status = ST_OOM;
              else begin
                last_d = want;
                state_d = S_SCAN;
              end
            end
            FUNC_FREE, FUNC_QUERY: begin
              idx_d = CW'(off >> PAGE_SHIFT);
              if (loc_ok) state_d = S_RD;
              else if (in_data_i.func == FUNC_QUERY) rsp_d.page_state = PG_BAD;
              else rsp_d.status = loc_st;
            end
            default: begin
              if (pool_q == '0) rsp_d.status = ST_NOT_INIT;
              else if (in_data_i.reserve_bytes == '0) rsp_d.status = ST_BAD_ARGS;
              else if ((((in_data_i.addr + in_data_i.reserve_bytes + PgMask) & ~PgMask)
                        <= ((in_data_i.addr & ~PgMask) < base_a ? base_a
                            : (in_data_i.addr & ~PgMask))))
                rsp_d.status = ST_BAD_ARGS;
              else if (rs_start >= limit_a) rsp_d.status = ST_OK;
              else begin
                idx_d  = CW'((rs_start - base_a) >> PAGE_SHIFT);
                last_d = CW'((rs_end - base_a) >> PAGE_SHIFT);
                if (last_d > pool_q) last_d = pool_q;
                state_d = S_RSV;
                fwd_d = 1'b0;
              end
            end
          endcase
        end
        if (cfg_we_i && cfg_idx_i == 1'(CfgIdxPool)) begin
          pool_d = CW'(cv); free_d = cv; used_d = '0; rsv_d = '0; peak_d = '0;
          idx_d = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == CW'(MAX_PAGES - 1)) state_d = S_IDLE;
      end
      // Scan: one page read per cycle; rd_q holds the page before idx_q.
      S_SCAN: begin
        raddr = idx_q[IW-1:0];
        if (idx_q < pool_q) idx_d = idx_q + 1'b1;
        if (fwd_q) begin
          if (rd_q == PG_FREE) begin
            if (run_q == '0) start_d = idx_q - 1'b1;
            run_d = run_q + 1'b1;
            if (run_d == last_q) begin
              idx_d = (run_q == '0) ? idx_q - 1'b1 : start_q;
              state_d = S_MARK;
            end
          end else run_d = '0;
        end
        fwd_d = (idx_q < pool_q) && (state_d == S_SCAN);
        if (!fwd_q && idx_q != '0 && idx_q >= pool_q) begin
          rsp_d.status = ST_OOM;
          state_d = S_RESP;
        end
        if (idx_q == '0) fwd_d = 1'b1;
      end
      S_MARK: begin
        we = 1'b1; wdat = PG_USED;
        idx_d = idx_q + 1'b1;
        run_d = run_q - 1'b1;
        if (run_q == CW'(1)) begin
          free_d = free_q - 13'(last_q);
          used_d = used_q + 13'(last_q);
          if (used_d > peak_q) peak_d = used_d;
          rsp_d.alloc_addr = base_a + 32'({start_q, {PAGE_SHIFT{1'b0}}});
          state_d = S_RESP;
        end
      end
      // Reserve: read a page, then decide on it the next cycle.
      S_RSV: begin
        if (idx_q >= last_q) state_d = S_RESP;
        else if (!fwd_q) begin
          fwd_d = 1'b1;
        end else begin
          fwd_d = 1'b0;
          if (rd_q == PG_USED) begin
            rsp_d.status = ST_USED;
            state_d = S_RESP;
          end else begin
            if (rd_q == PG_FREE) begin
              we = 1'b1; wdat = PG_RSVD;
              free_d = free_q - 1'b1;
              rsv_d = rsv_q + 1'b1;
            end
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_RD: begin
        if (!fwd_q) fwd_d = 1'b1;
        else begin
          fwd_d = 1'b0;
          state_d = S_RESP;
          if (req_q.func == FUNC_QUERY) rsp_d.page_state = rd_q;
          else if (rd_q == PG_FREE) rsp_d.status = ST_DBL_FREE;
          else if (rd_q == PG_RSVD) rsp_d.status = ST_RESERVED;
          else begin
            we = 1'b1; wdat = PG_FREE;
            used_d = used_q - 1'b1;
            free_d = free_q + 1'b1;
          end
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && in_valid_i && state_d == S_RD) fwd_d = 1'b0;
    if (state_q == S_IDLE && state_d == S_SCAN) fwd_d = 1'b0;
  end

  always_comb begin
    out_data_o = rsp_q;
    out_data_o.free_count = free_q;
    out_data_o.used_count = used_q;
    out_data_o.reserved_count = rsv_q;
    out_data_o.peak_count = peak_q;
  end

`ifndef SYNTHESIS
  a_used_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= peak_q) else $error("used above peak");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("ready while busy");
  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rsp_q))
    else $error("result changed while stalled");
`endif

endmodule
